/* design/lpfp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Length-prefixed frame parser package
// Shared types, event codes and constants for the frame parser.
// ----------------------------------------------------------------------------
package lpfp_pkg;

  // Frame header and buffer sizing.
  localparam int unsigned LengthBytes = 4;
  localparam int unsigned HdrCntW     = $clog2(LengthBytes);
  localparam int unsigned CapW        = 25;
  localparam logic [CapW-1:0] CapReset = 25'd65536;

  // Header words that select the special request handlers (little-endian).
  localparam logic [31:0] PolicyHead = 32'h6C6F703C;  // "<pol"
  localparam logic [31:0] GetHead    = 32'h20544547;  // "GET "

  // Policy request string length and the index width that walks it.
  localparam int unsigned PolicyLen  = 22;
  localparam int unsigned PolicyIdxW = 5;

  // Characters of the HTTP header terminator.
  localparam logic [7:0] CharCr = 8'h0D;
  localparam logic [7:0] CharLf = 8'h0A;

  typedef logic [7:0]      byte_t;
  typedef logic [CapW-1:0] cap_t;

  // Result event codes.
  typedef enum logic [2:0] {
    EV_NONE     = 3'd0,
    EV_BYTE     = 3'd1,
    EV_EMPTY    = 3'd2,
    EV_POLICY   = 3'd3,
    EV_HTTP     = 3'd4,
    EV_PKTERR   = 3'd5,
    EV_OVERFLOW = 3'd6
  } event_kind_e;

  // Parser phase, one-hot.
  typedef enum logic [4:0] {
    PH_HEADER  = 5'b00001,
    PH_PAYLOAD = 5'b00010,
    PH_POLICY  = 5'b00100,
    PH_HTTP    = 5'b01000,
    PH_CLOSED  = 5'b10000
  } phase_e;

  // One result beat.
  typedef struct packed {
    event_kind_e event_kind;
    byte_t       payload_data;
    logic        last_of_packet;
  } result_t;

  // Character of "<policy-file-request/>" at a given position.
  function automatic byte_t policy_char(input logic [PolicyIdxW-1:0] idx);
    byte_t ch;
    unique case (idx)
      5'd0:    ch = "<";
      5'd1:    ch = "p";
      5'd2:    ch = "o";
      5'd3:    ch = "l";
      5'd4:    ch = "i";
      5'd5:    ch = "c";
      5'd6:    ch = "y";
      5'd7:    ch = "-";
      5'd8:    ch = "f";
      5'd9:    ch = "i";
      5'd10:   ch = "l";
      5'd11:   ch = "e";
      5'd12:   ch = "-";
      5'd13:   ch = "r";
      5'd14:   ch = "e";
      5'd15:   ch = "q";
      5'd16:   ch = "u";
      5'd17:   ch = "e";
      5'd18:   ch = "s";
      5'd19:   ch = "t";
      5'd20:   ch = "/";
      5'd21:   ch = ">";
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

/* design/lpfp_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame parser channel interfaces
// Valid/ready channels for received bytes, result events and the
// buffer capacity register write.
// ----------------------------------------------------------------------------
interface lpfp_byte_if;
  logic             valid;
  logic             ready;
  lpfp_pkg::byte_t  rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface lpfp_event_if;
  logic                    valid;
  logic                    ready;
  lpfp_pkg::event_kind_e   event_kind;
  lpfp_pkg::byte_t         payload_data;
  logic                    last_of_packet;

  modport source (output valid, output event_kind, output payload_data,
                  output last_of_packet, input ready);
  modport sink   (input valid, input event_kind, input payload_data,
                  input last_of_packet, output ready);
endinterface

interface lpfp_cfg_if;
  logic            valid;
  logic            ready;
  lpfp_pkg::cap_t  buffer_capacity;

  modport source (output valid, output buffer_capacity, input ready);
  modport sink   (input valid, input buffer_capacity, output ready);
endinterface

/* design/lpfp_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame parser core
// Holds the parse state and computes one result per accepted byte.
// ----------------------------------------------------------------------------
module lpfp_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  lpfp_pkg::byte_t   rx_byte_i,
  input  lpfp_pkg::cap_t    cap_i,
  output lpfp_pkg::result_t result_o
);
  import lpfp_pkg::*;

  phase_e                phase_q, phase_d;
  logic [31:0]           hdr_q, hdr_d;
  logic [HdrCntW-1:0]    hcnt_q, hcnt_d;
  logic [PolicyIdxW-1:0] pidx_q, pidx_d;
  cap_t                  http_cnt_q, http_cnt_d;
  logic [1:0]            term_q, term_d;
  cap_t                  remain_q, remain_d;

  logic [31:0]  hdr_new;
  logic [32:0]  frame_total;
  cap_t         http_inc;
  logic         http_done;

  assign hdr_new     = {rx_byte_i, hdr_q[31:8]};
  assign frame_total = {1'b0, hdr_new} + 33'(LengthBytes);
  assign http_inc    = http_cnt_q + cap_t'(1);

  // Next-state and result logic for one byte.
  always_comb begin
    phase_d    = phase_q;
    hdr_d      = hdr_q;
    hcnt_d     = hcnt_q;
    pidx_d     = pidx_q;
    http_cnt_d = http_cnt_q;
    term_d     = term_q;
    remain_d   = remain_q;
    http_done  = 1'b0;
    result_o   = '{event_kind: EV_NONE, payload_data: 8'h00, last_of_packet: 1'b0};

    unique case (phase_q)
      PH_HEADER: begin
        hdr_d  = hdr_new;
        hcnt_d = hcnt_q + HdrCntW'(1);
        if (hcnt_q == HdrCntW'(LengthBytes - 1)) begin
          hcnt_d = '0;
          if (hdr_new == PolicyHead) begin
            pidx_d  = PolicyIdxW'(LengthBytes);
            phase_d = PH_POLICY;
          end else if (hdr_new == GetHead) begin
            http_cnt_d = cap_t'(LengthBytes);
            term_d     = 2'd0;
            phase_d    = PH_HTTP;
            if (cap_t'(LengthBytes) >= cap_i) begin
              phase_d             = PH_CLOSED;
              result_o.event_kind = EV_OVERFLOW;
            end
          end else if (frame_total > {8'h00, cap_i}) begin
            phase_d             = PH_CLOSED;
            result_o.event_kind = EV_PKTERR;
          end else if (hdr_new == 32'd0) begin
            result_o.event_kind = EV_EMPTY;
          end else begin
            remain_d = hdr_new[CapW-1:0];
            phase_d  = PH_PAYLOAD;
          end
        end
      end

      PH_PAYLOAD: begin
        result_o.event_kind   = EV_BYTE;
        result_o.payload_data = rx_byte_i;
        if (remain_q <= cap_t'(1)) begin
          remain_d                = '0;
          phase_d                 = PH_HEADER;
          result_o.last_of_packet = 1'b1;
        end else begin
          remain_d = remain_q - cap_t'(1);
        end
      end

      PH_POLICY: begin
        if (pidx_q >= PolicyIdxW'(PolicyLen) || rx_byte_i != policy_char(pidx_q)) begin
          phase_d             = PH_CLOSED;
          result_o.event_kind = EV_PKTERR;
        end else begin
          pidx_d = pidx_q + PolicyIdxW'(1);
          if (pidx_d == PolicyIdxW'(PolicyLen)) begin
            phase_d             = PH_CLOSED;
            result_o.event_kind = EV_POLICY;
          end
        end
      end

      PH_HTTP: begin
        http_cnt_d = http_inc;
        // Track progress through the CR LF CR LF terminator.
        if (rx_byte_i == CharCr) begin
          term_d = (term_q == 2'd2) ? 2'd3 : 2'd1;
        end else if (rx_byte_i == CharLf && term_q == 2'd1) begin
          term_d = 2'd2;
        end else if (rx_byte_i == CharLf && term_q == 2'd3) begin
          http_done = 1'b1;
          term_d    = 2'd0;
        end else begin
          term_d = 2'd0;
        end
        if (http_done) begin
          http_cnt_d          = '0;
          phase_d             = PH_HEADER;
          result_o.event_kind = EV_HTTP;
        end else if (http_inc >= cap_i) begin
          phase_d             = PH_CLOSED;
          result_o.event_kind = EV_OVERFLOW;
        end
      end

      // Closed, and any unused code, ignores the byte.
      default: begin
      end
    endcase
  end

  // State registers advance only on an accepted beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_HEADER;
      hdr_q      <= '0;
      hcnt_q     <= '0;
      pidx_q     <= '0;
      http_cnt_q <= '0;
      term_q     <= '0;
      remain_q   <= '0;
    end else if (fire_i) begin
      phase_q    <= phase_d;
      hdr_q      <= hdr_d;
      hcnt_q     <= hcnt_d;
      pidx_q     <= pidx_d;
      http_cnt_q <= http_cnt_d;
      term_q     <= term_d;
      remain_q   <= remain_d;
    end
  end

  // The phase register never holds more or less than one active bit.
  assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot(phase_q))
    else $error("parser phase is not one-hot");

  // Once closed, the parser stays closed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (fire_i && phase_q == PH_CLOSED) |=> phase_q == PH_CLOSED)
    else $error("parser left the closed phase");

  // A payload phase always has at least one byte left to pass.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   phase_q == PH_PAYLOAD |-> remain_q != '0)
    else $error("payload phase with no bytes remaining");

  // End-of-packet marks only a payload byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   result_o.last_of_packet |-> result_o.event_kind == EV_BYTE)
    else $error("last marker on a non-payload event");

endmodule

/* design/lpfp_out_reg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame parser result register
// Holds one result beat and lets a new beat load when empty or when the held one
// is taken in the same cycle.
// ----------------------------------------------------------------------------
module lpfp_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  lpfp_pkg::result_t result_i,
  output logic              can_load_o,
  lpfp_event_if.source      ev_o
);
  import lpfp_pkg::*;

  logic    valid_q;
  result_t data_q;

  // Space is free when empty or when the held beat leaves this cycle.
  assign can_load_o = !valid_q || ev_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (ev_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  // Payload register, no reset needed.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= result_i;
    end
  end

  assign ev_o.valid          = valid_q;
  assign ev_o.event_kind     = data_q.event_kind;
  assign ev_o.payload_data   = data_q.payload_data;
  assign ev_o.last_of_packet = data_q.last_of_packet;

endmodule

/* design/length_prefixed_frame_parser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Length-prefixed frame parser
// A result beat is registered and appears the cycle after its byte is accepted.
// One byte per cycle while results drain; every byte yields exactly one beat.
// Input ready follows the result register: free, or emptied in the same cycle.
// Reset: phase returns to header, counters clear, capacity returns to 65536.
// ----------------------------------------------------------------------------
module length_prefixed_frame_parser (
  input  logic          clk_i,
  input  logic          rst_ni,
  lpfp_byte_if.sink     rx_i,
  lpfp_cfg_if.sink      cfg_i,
  lpfp_event_if.source  ev_o
);
  import lpfp_pkg::*;

  cap_t    cap_q;
  logic    can_load;
  logic    fire;
  result_t result;

  // Capacity register; writes are always taken.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CapReset;
    end else if (cfg_i.valid) begin
      cap_q <= cfg_i.buffer_capacity;
    end
  end

  // A byte beat is accepted when the result register can take its result.
  assign rx_i.ready = can_load;
  assign fire       = rx_i.valid && can_load;

  lpfp_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (fire),
    .rx_byte_i (rx_i.rx_byte),
    .cap_i     (cap_q),
    .result_o  (result)
  );

  lpfp_out_reg u_out_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (fire),
    .result_i   (result),
    .can_load_o (can_load),
    .ev_o       (ev_o)
  );

endmodule
